### hdl/puvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Picture unit register port package
// Shared types, register numbers, memory sizes and raster timing constants.
// ----------------------------------------------------------------------------
package puvt_pkg;

  // Memory sizes.
  localparam int NAME_RAM_BYTES = 4096;
  localparam int NAME_AW        = $clog2(NAME_RAM_BYTES);
  localparam int PALETTE_BYTES  = 32;
  localparam int PAL_AW         = $clog2(PALETTE_BYTES);

  // Video address width after the 14-bit mask.
  localparam int VADDR_W = 14;

  // Register numbers on the CPU side.
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_MASK   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_SCROLL = 3'd5;
  localparam logic [2:0] REG_ADDR   = 3'd6;
  localparam logic [2:0] REG_DATA   = 3'd7;

  // Raster timing.
  localparam logic [8:0]        LAST_DOT     = 9'd340;
  localparam logic [8:0]        EVENT_DOT    = 9'd1;
  localparam logic signed [9:0] LAST_LINE    = 10'sd260;
  localparam logic signed [9:0] PRE_LINE     = -10'sd1;
  localparam logic signed [9:0] VBLANK_LINE  = 10'sd241;

  // Top six bits of the video address that select palette space.
  localparam logic [5:0] PALETTE_PAGE = 6'h3F;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_e;

  typedef enum logic [1:0] {
    RG_PATTERN,
    RG_NAME,
    RG_PALETTE
  } region_e;

endpackage

### hdl/puvt_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command channel
// Carries one register read, register write or dot tick request.
// ----------------------------------------------------------------------------
interface puvt_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [2:0] reg_select;
  logic [7:0] write_data;

  modport source (output valid, output command, output reg_select, output write_data,
                  input ready);
  modport sink (input valid, input command, input reg_select, input write_data,
                output ready);
endinterface

### hdl/puvt_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Carries the read byte and the interrupt and frame flags after each request.
// ----------------------------------------------------------------------------
interface puvt_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       nmi_request;
  logic       vblank_flag;
  logic       frame_done;

  modport source (output valid, output read_data, output nmi_request,
                  output vblank_flag, output frame_done, input ready);
  modport sink (input valid, input read_data, input nmi_request,
                input vblank_flag, input frame_done, output ready);
endinterface

### hdl/puvt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module puvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### hdl/picture_unit_register_vram_timing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Picture unit register port with video memory and raster timing
// CPU register interface, name-table and palette RAM, dot and line counters.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  cmd_i   | in        | command, reg_select, write_data
//  rsp_o   | out       | read_data, nmi_request, vblank_flag, frame_done
//
//  A data register read passes through the ST_READ state before its response
//  is loaded, because the video RAM read data is registered.
//  After reset a clearing pass zeroes both RAMs; no request
//  is taken until it ends.
//  The response sits in an output register; in the idle state a new request
//  is taken when that register is empty or is being emptied in the same cycle.
// ----------------------------------------------------------------------------
module picture_unit_register_vram_timing
  import puvt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  puvt_cmd_if.sink    cmd_i,
  puvt_rsp_if.source  rsp_o
);

  state_e              state_q, state_d;
  logic [NAME_AW-1:0]  clr_cnt_q, clr_cnt_d;

  // Control bits that matter: nmi enable, increment by 32, name-table select.
  // Mask and fine x writes have no effect as background rendering is absent.
  logic                nmi_en_q, nmi_en_d;
  logic                inc32_q, inc32_d;
  logic                toggle_q, toggle_d;
  logic [VADDR_W-1:0]  temp_q, temp_d;
  logic [VADDR_W-1:0]  vaddr_q, vaddr_d;
  logic [7:0]          rbuf_q, rbuf_d;
  logic [8:0]          dot_q, dot_d;
  logic signed [9:0]   line_q, line_d;
  logic                frame_q, frame_d;
  logic                nmi_q, nmi_d;
  logic                vblank_q, vblank_d;
  region_e             region_q, region_d;

  logic                rsp_valid_q, rsp_valid_d;
  logic [7:0]          rsp_data_q, rsp_data_d;
  logic                rsp_nmi_q, rsp_vblank_q, rsp_frame_q;
  logic                rsp_load;

  logic                accept;
  logic                cmd_ready;
  region_e             vregion;
  logic [VADDR_W-1:0]  vaddr_inc;
  logic [7:0]          new_buf;

  logic                name_we, pal_we;
  logic [NAME_AW-1:0]  name_addr;
  logic [PAL_AW-1:0]   pal_addr;
  logic [7:0]          name_wdata, pal_wdata;
  logic [7:0]          name_rdata, pal_rdata;

  // Video memories.
  puvt_ram #(.WIDTH(8), .DEPTH(NAME_RAM_BYTES)) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (name_we),
    .addr_i  (name_addr),
    .wdata_i (name_wdata),
    .rdata_o (name_rdata)
  );

  puvt_ram #(.WIDTH(8), .DEPTH(PALETTE_BYTES)) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .addr_i  (pal_addr),
    .wdata_i (pal_wdata),
    .rdata_o (pal_rdata)
  );

  assign cmd_ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_o.ready);
  assign accept    = cmd_i.valid && cmd_ready;

  // Decode the region of the current video address.
  always_comb begin
    if (vaddr_q[VADDR_W-1:8] == PALETTE_PAGE) begin
      vregion = RG_PALETTE;
    end else if (vaddr_q[VADDR_W-1]) begin
      vregion = RG_NAME;
    end else begin
      vregion = RG_PATTERN;
    end
  end

  assign vaddr_inc = vaddr_q + (inc32_q ? VADDR_W'(32) : VADDR_W'(1));

  // Byte fetched for the read buffer, in the cycle after the RAM read was issued.
  always_comb begin
    case (region_q)
      RG_NAME:    new_buf = name_rdata;
      RG_PALETTE: new_buf = pal_rdata;
      default:    new_buf = 8'h00;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == NAME_AW'(NAME_RAM_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (cmd_i.command == CMD_READ) && (cmd_i.reg_select == REG_DATA)) begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Register updates, memory accesses and response loading.
  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    nmi_en_d   = nmi_en_q;
    inc32_d    = inc32_q;
    toggle_d   = toggle_q;
    temp_d     = temp_q;
    vaddr_d    = vaddr_q;
    rbuf_d     = rbuf_q;
    dot_d      = dot_q;
    line_d     = line_q;
    frame_d    = frame_q;
    nmi_d      = nmi_q;
    vblank_d   = vblank_q;
    region_d   = region_q;
    rsp_load   = 1'b0;
    rsp_data_d = 8'h00;
    name_we    = 1'b0;
    pal_we     = 1'b0;
    name_addr  = vaddr_q[NAME_AW-1:0];
    pal_addr   = vaddr_q[PAL_AW-1:0];
    name_wdata = cmd_i.write_data;
    pal_wdata  = cmd_i.write_data;

    case (state_q)
      ST_CLEAR: begin
        // Sweep both RAMs with zeros; the palette wraps over its low bits.
        name_we    = 1'b1;
        pal_we     = 1'b1;
        name_addr  = clr_cnt_q;
        pal_addr   = clr_cnt_q[PAL_AW-1:0];
        name_wdata = 8'h00;
        pal_wdata  = 8'h00;
        clr_cnt_d  = clr_cnt_q + NAME_AW'(1);
      end

      ST_IDLE: begin
        if (accept) begin
          rsp_load = 1'b1;
          case (cmd_i.command)
            CMD_READ: begin
              if (cmd_i.reg_select == REG_STATUS) begin
                rsp_data_d = {vblank_q, 2'b00, rbuf_q[4:0]};
                vblank_d   = 1'b0;
                toggle_d   = 1'b0;
              end else if (cmd_i.reg_select == REG_DATA) begin
                // RAM read is under way; the response is loaded in the ST_READ state.
                rsp_load = 1'b0;
                region_d = vregion;
                vaddr_d  = vaddr_inc;
              end
            end

            CMD_WRITE: begin
              case (cmd_i.reg_select)
                REG_CTRL: begin
                  nmi_en_d      = cmd_i.write_data[7];
                  inc32_d       = cmd_i.write_data[2];
                  temp_d[11:10] = cmd_i.write_data[1:0];
                end
                REG_SCROLL: begin
                  if (!toggle_q) begin
                    temp_d[4:0] = cmd_i.write_data[7:3];
                    toggle_d    = 1'b1;
                  end else begin
                    temp_d[13:12] = cmd_i.write_data[1:0];
                    temp_d[9:5]   = cmd_i.write_data[7:3];
                    toggle_d      = 1'b0;
                  end
                end
                REG_ADDR: begin
                  if (!toggle_q) begin
                    temp_d[13:8] = cmd_i.write_data[5:0];
                    toggle_d     = 1'b1;
                  end else begin
                    temp_d[7:0] = cmd_i.write_data;
                    vaddr_d     = {temp_q[13:8], cmd_i.write_data};
                    toggle_d    = 1'b0;
                  end
                end
                REG_DATA: begin
                  name_we = (vregion == RG_NAME);
                  pal_we  = (vregion == RG_PALETTE);
                  vaddr_d = vaddr_inc;
                end
                default: begin
                end
              endcase
            end

            CMD_TICK: begin
              // Advance the raster position, then apply the dot-one events.
              if (dot_q == LAST_DOT) begin
                dot_d = 9'd0;
                if (line_q == LAST_LINE) begin
                  line_d  = PRE_LINE;
                  frame_d = 1'b1;
                end else begin
                  line_d = line_q + 10'sd1;
                end
              end else begin
                dot_d = dot_q + 9'd1;
              end
              if ((line_d == VBLANK_LINE) && (dot_d == EVENT_DOT)) begin
                vblank_d = 1'b1;
                if (nmi_en_q) begin
                  nmi_d = 1'b1;
                end
              end
              if ((line_d == PRE_LINE) && (dot_d == EVENT_DOT)) begin
                vblank_d = 1'b0;
                frame_d  = 1'b0;
                nmi_d    = 1'b0;
              end
            end

            default: begin
            end
          endcase
        end
      end

      ST_READ: begin
        // Palette reads bypass the buffer; others return the old contents.
        rsp_load   = 1'b1;
        rbuf_d     = new_buf;
        rsp_data_d = (region_q == RG_PALETTE) ? new_buf : rbuf_q;
      end

      default: begin
      end
    endcase
  end

  assign rsp_valid_d = rsp_load || (rsp_valid_q && !rsp_o.ready);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      nmi_en_q    <= 1'b0;
      inc32_q     <= 1'b0;
      toggle_q    <= 1'b0;
      temp_q      <= '0;
      vaddr_q     <= '0;
      rbuf_q      <= 8'h00;
      dot_q       <= 9'd0;
      line_q      <= 10'sd0;
      frame_q     <= 1'b0;
      nmi_q       <= 1'b0;
      vblank_q    <= 1'b0;
      region_q    <= RG_PATTERN;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      nmi_en_q    <= nmi_en_d;
      inc32_q     <= inc32_d;
      toggle_q    <= toggle_d;
      temp_q      <= temp_d;
      vaddr_q     <= vaddr_d;
      rbuf_q      <= rbuf_d;
      dot_q       <= dot_d;
      line_q      <= line_d;
      frame_q     <= frame_d;
      nmi_q       <= nmi_d;
      vblank_q    <= vblank_d;
      region_q    <= region_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Response payload register; flags are taken after the request's update.
  always_ff @(posedge clk_i) begin
    if (rsp_load) begin
      rsp_data_q   <= rsp_data_d;
      rsp_nmi_q    <= nmi_d;
      rsp_vblank_q <= vblank_d;
      rsp_frame_q  <= frame_d;
    end
  end

  assign cmd_i.ready       = cmd_ready;
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.read_data   = rsp_data_q;
  assign rsp_o.nmi_request = rsp_nmi_q;
  assign rsp_o.vblank_flag = rsp_vblank_q;
  assign rsp_o.frame_done  = rsp_frame_q;

`ifndef SYNTHESIS
  // No request is taken while the RAMs are being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !cmd_i.ready)
    else $error("request accepted during clearing pass");

  // A pending data read always finds the response register empty.
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !rsp_valid_q)
    else $error("response register busy during data read");

  // A data register read is followed by the RAM data cycle.
  a_data_read_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd_i.command == CMD_READ) && (cmd_i.reg_select == REG_DATA))
    |=> (state_q == ST_READ) && !rsp_valid_q)
    else $error("data read did not wait for RAM data");

  // The dot counter stays within one line.
  a_dot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dot_q <= LAST_DOT)
    else $error("dot counter out of range");

  // The line counter stays between the prerender line and the last line.
  a_line_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_q >= PRE_LINE) && (line_q <= LAST_LINE))
    else $error("line counter out of range");
`endif

endmodule
